FILE: sv/tribonacci_mod_matrix_power_top_assert.svh
// Assertion macros shared by the tribonacci matrix power modules.
`ifndef TRIBONACCI_MOD_MATRIX_POWER_TOP_ASSERT_SVH
`define TRIBONACCI_MOD_MATRIX_POWER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define TMMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define TMMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TMMP_ASSERT(label, prop, msg)
`define TMMP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: sv/tmmp_pkg.sv
// Types, constants and modular helpers for the tribonacci matrix power block.
`timescale 1ns / 1ps
`default_nettype none

package tmmp_pkg;

    localparam int ELEM_W = 30;
    localparam int CNT_W  = $clog2(ELEM_W);

    typedef logic [ELEM_W-1:0] elem_t;
    // Row index, then column index, then element bits.
    typedef logic [2:0][2:0][ELEM_W-1:0] mat_t;

    localparam elem_t MODULUS = 30'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_WRITE
    } tmmp_state_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_TRIPLE,
        MM_RUN,
        MM_DONE
    } mm_state_t;

    // Add two residues and fold the sum back below the modulus.
    function automatic elem_t mod_add(input elem_t a, input elem_t b);
        logic [ELEM_W:0]   s;
        logic [ELEM_W+1:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = {1'b0, s} - {2'b0, MODULUS};
        return d[ELEM_W+1] ? s[ELEM_W-1:0] : d[ELEM_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/tmmp_matmul.sv
// Bit-serial 3x3 modular matrix product: nine lanes, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "tribonacci_mod_matrix_power_top_assert.svh"

module tmmp_matmul
    import tmmp_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    input  wire mat_t  x,
    input  wire mat_t  y,
    output logic       done,
    output mat_t       z
);

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(ELEM_W - 1);

    mm_state_t           state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    mat_t                xs_reg, xs_next;
    mat_t                lane_reg, lane_next;
    // Column j: pair sums y0+y1, y0+y2, y1+y2.
    logic [2:0][2:0][ELEM_W-1:0] pair_reg, pair_next;
    logic [2:0][ELEM_W-1:0]      trip_reg, trip_next;
    logic                load_en;
    logic                trip_en;
    logic                step_en;
    logic                lanes_ok;

    // Pick the sum of the column entries whose multiplier bits are set.
    function automatic elem_t pick_sum(
        input logic [2:0] code,
        input elem_t y0, input elem_t y1, input elem_t y2,
        input elem_t p01, input elem_t p02, input elem_t p12, input elem_t p012
    );
        elem_t r;
        case (code)
            3'd1:    r = y0;
            3'd2:    r = y1;
            3'd3:    r = p01;
            3'd4:    r = y2;
            3'd5:    r = p02;
            3'd6:    r = p12;
            3'd7:    r = p012;
            default: r = '0;
        endcase
        return r;
    endfunction

    // One Horner step: 2r + s, folded below the modulus.
    function automatic elem_t dbl_add(input elem_t r, input elem_t s);
        logic [ELEM_W+1:0] t;
        logic [ELEM_W+2:0] t1;
        logic [ELEM_W+2:0] t2;
        elem_t             q;
        t  = {1'b0, r, 1'b0} + {2'b0, s};
        t1 = {1'b0, t} - {3'b0, MODULUS};
        t2 = {1'b0, t} - {2'b0, MODULUS, 1'b0};
        if (!t2[ELEM_W+2]) begin
            q = t2[ELEM_W-1:0];
        end
        else if (!t1[ELEM_W+2]) begin
            q = t1[ELEM_W-1:0];
        end
        else begin
            q = t[ELEM_W-1:0];
        end
        return q;
    endfunction

    // Advance the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MM_IDLE:
            begin
                if (start)
                begin
                    state_next = MM_TRIPLE;
                end
            end
            MM_TRIPLE:
            begin
                state_next = MM_RUN;
            end
            MM_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = MM_DONE;
                end
            end
            MM_DONE:
            begin
                state_next = MM_IDLE;
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase
    end

    // Decode the sequencer outputs.
    always_comb
    begin
        load_en = 1'b0;
        trip_en = 1'b0;
        step_en = 1'b0;
        done    = 1'b0;
        case (state_reg)
            MM_IDLE:   load_en = start;
            MM_TRIPLE: trip_en = 1'b1;
            MM_RUN:    step_en = 1'b1;
            MM_DONE:   done    = 1'b1;
            default:   done    = 1'b0;
        endcase
    end

    // Load operands, build column subset sums, and run the lanes.
    always_comb
    begin
        cnt_next  = cnt_reg;
        xs_next   = xs_reg;
        lane_next = lane_reg;
        pair_next = pair_reg;
        trip_next = trip_reg;
        if (load_en)
        begin
            cnt_next  = LAST_BIT;
            xs_next   = x;
            lane_next = '0;
            for (int j = 0; j < 3; j++)
            begin
                pair_next[j][0] = mod_add(y[0][j], y[1][j]);
                pair_next[j][1] = mod_add(y[0][j], y[2][j]);
                pair_next[j][2] = mod_add(y[1][j], y[2][j]);
            end
        end
        if (trip_en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                trip_next[j] = mod_add(pair_reg[j][0], y[2][j]);
            end
        end
        if (step_en)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lane_next[i][j] = dbl_add(lane_reg[i][j],
                        pick_sum({xs_reg[i][2][ELEM_W-1], xs_reg[i][1][ELEM_W-1],
                                  xs_reg[i][0][ELEM_W-1]},
                                 y[0][j], y[1][j], y[2][j],
                                 pair_reg[j][0], pair_reg[j][1], pair_reg[j][2],
                                 trip_reg[j]));
                end
                for (int k = 0; k < 3; k++)
                begin
                    xs_next[i][k] = {xs_reg[i][k][ELEM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        xs_reg   <= xs_next;
        lane_reg <= lane_next;
        pair_reg <= pair_next;
        trip_reg <= trip_next;
    end

    assign z = lane_reg;

    // Flag that every lane holds a reduced residue.
    always_comb
    begin
        lanes_ok = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (lane_reg[i][j] >= MODULUS)
                begin
                    lanes_ok = 1'b0;
                end
            end
        end
    end

    `TMMP_ASSERT_NEXT(a_run_ends, state_reg == MM_RUN && cnt_reg == '0, state_reg == MM_DONE, "multiply pass did not end after the last bit")
    `TMMP_ASSERT(a_lanes_reduced, (state_reg == MM_DONE) |-> lanes_ok, "product entry not reduced")
    `TMMP_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")

endmodule

`default_nettype wire

FILE: sv/tribonacci_mod_matrix_power_top.sv
// Tribonacci number modulo 1000000007 by square-and-multiply of the companion matrix.
// An index below 3 skips the matrix products and goes straight from the check to the write.
// The block takes one item at a time: a new index is accepted only in idle, after the last result is written.
// Each matrix product runs in the shared bit-serial unit (30-bit multiplier pass).
// Reset (rst_n, asynchronous, active low) returns the block to idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "tribonacci_mod_matrix_power_top_assert.svh"

module tribonacci_mod_matrix_power_top
    import tmmp_pkg::*;
#(
    parameter int INDEX_BITS = 32
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   req_valid,
    output logic                  req_stall,
    input  wire [INDEX_BITS-1:0]  index,
    output logic                  rsp_valid,
    input  wire                   rsp_stall,
    output logic [ELEM_W-1:0]     value
);

    tmmp_state_t            state_reg, state_next;
    logic [INDEX_BITS-1:0]  e_reg, e_next;
    mat_t                   acc_reg, acc_next;
    mat_t                   base_reg, base_next;
    elem_t                  value_reg, value_next;
    logic                   valid_reg, valid_next;
    logic                   take_en;
    logic                   write_en;
    logic                   out_free;
    logic                   mm_start;
    logic                   mm_done;
    mat_t                   mm_y;
    mat_t                   mm_z;

    assign out_free = !valid_reg || !rsp_stall;

    // Advance the exponent walk.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_WRITE;
                end
                else if (e_reg[0])
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (mm_done)
                begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mm_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Decode handshake and unit controls.
    always_comb
    begin
        req_stall = 1'b1;
        take_en   = 1'b0;
        write_en  = 1'b0;
        mm_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                take_en   = req_valid;
            end
            ST_MUL:   mm_start = 1'b1;
            ST_SQR:   mm_start = 1'b1;
            ST_WRITE: write_en = out_free;
            default:  req_stall = 1'b1;
        endcase
    end

    // Multiply feeds base*acc, square feeds base*base.
    assign mm_y = (state_reg == ST_MUL) ? acc_reg : base_reg;

    // Load the item, fold in products, and hold the result.
    always_comb
    begin
        e_next     = e_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        if (take_en)
        begin
            e_next   = (index > INDEX_BITS'(2)) ? index - INDEX_BITS'(2) : '0;
            acc_next = '0;
            if (index != '0)
            begin
                acc_next[0][0] = elem_t'(1);
                acc_next[1][1] = elem_t'(1);
                acc_next[2][2] = elem_t'(1);
            end
            base_next       = '0;
            base_next[0][0] = elem_t'(1);
            base_next[0][1] = elem_t'(1);
            base_next[0][2] = elem_t'(1);
            base_next[1][0] = elem_t'(1);
            base_next[2][1] = elem_t'(1);
        end
        if (state_reg == ST_MUL && mm_done)
        begin
            acc_next = mm_z;
        end
        if (state_reg == ST_SQR && mm_done)
        begin
            base_next = mm_z;
            e_next    = e_reg >> 1;
        end
        if (write_en)
        begin
            value_next = mod_add(acc_reg[0][0], acc_reg[0][1]);
            valid_next = 1'b1;
        end
        else if (valid_reg && !rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg     <= e_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        value_reg <= value_next;
    end

    tmmp_matmul u_matmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x     (base_reg),
        .y     (mm_y),
        .done  (mm_done),
        .z     (mm_z)
    );

    assign rsp_valid = valid_reg;
    assign value     = value_reg;

    `TMMP_ASSERT(a_value_range, valid_reg |-> (value_reg < MODULUS), "result not below the modulus")
    `TMMP_ASSERT_NEXT(a_accept_locks, req_valid && !req_stall, req_stall, "second transfer taken while busy")
    `TMMP_ASSERT_NEXT(a_exp_shift, state_reg == ST_SQR && mm_done, e_reg == ($past(e_reg) >> 1), "exponent did not advance after squaring")

endmodule

`default_nettype wire
